>>> rtl/cc_cv_charge_controller_core_defines.svh
// Assertion macros used by the charge controller checker.
`ifndef CC_CV_CHARGE_CONTROLLER_CORE_DEFINES_SVH
`define CC_CV_CHARGE_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCCV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCCV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cccv_pkg.sv
// Types and constants of the CC/CV charge controller.
`timescale 1ns / 1ps

package cccv_pkg;

    // Charge mode as carried on the result word
    typedef enum logic [1:0] {
        MODE_CC      = 2'd0,
        MODE_CV      = 2'd1,
        MODE_CHARGED = 2'd2,
        MODE_ERROR   = 2'd3
    } mode_t;

    // Register file geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int LEVEL_W     = 15;
    localparam int INIT_DUTY_W = 10;
    localparam int DUTY_PORT_W = 10;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CC_TARGET_CURRENT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CV_TARGET_VOLTAGE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CC_TO_CV_VOLTAGE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF_CURRENT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR_CURRENT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DUTY      = 3'd5;

    // Register reset values
    localparam logic [LEVEL_W-1:0]     RST_CC_TARGET_CURRENT = 15'd1000;
    localparam logic [LEVEL_W-1:0]     RST_CV_TARGET_VOLTAGE = 15'd4200;
    localparam logic [LEVEL_W-1:0]     RST_CC_TO_CV_VOLTAGE  = 15'd4100;
    localparam logic [LEVEL_W-1:0]     RST_CUTOFF_CURRENT    = 15'd100;
    localparam logic [LEVEL_W-1:0]     RST_FLOOR_CURRENT     = 15'd10;
    localparam logic [INIT_DUTY_W-1:0] RST_INITIAL_DUTY      = 10'd100;

    // Configuration register set
    typedef struct packed {
        logic [LEVEL_W-1:0]     cc_target_current;
        logic [LEVEL_W-1:0]     cv_target_voltage;
        logic [LEVEL_W-1:0]     cc_to_cv_voltage;
        logic [LEVEL_W-1:0]     cutoff_current;
        logic [LEVEL_W-1:0]     floor_current;
        logic [INIT_DUTY_W-1:0] initial_duty;
    } cfg_t;

endpackage

>>> rtl/cccv_sample_if.sv
// Valid/ready channel carrying one current/voltage sample word.
`timescale 1ns / 1ps

interface cccv_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] measured_current;
    logic signed [SAMPLE_WIDTH-1:0] measured_voltage;
    logic                           fault;
    logic                           reset_request;

    modport source (
        output valid, measured_current, measured_voltage, fault, reset_request,
        input  ready
    );
    modport sink (
        input  valid, measured_current, measured_voltage, fault, reset_request,
        output ready
    );
endinterface

>>> rtl/cccv_result_if.sv
// Valid/ready channel carrying one duty/mode result word.
`timescale 1ns / 1ps

interface cccv_result_if;
    logic       valid;
    logic       ready;
    logic [9:0] duty;
    logic [1:0] mode;

    modport source (
        output valid, duty, mode,
        input  ready
    );
    modport sink (
        input  valid, duty, mode,
        output ready
    );
endinterface

>>> rtl/cc_cv_charge_controller_core.sv
// CC/CV charge controller core: input register, control tick and result register.
`timescale 1ns / 1ps

// Takes one sample word per clock and returns one result word per sample,
// in order. A word is registered on entry, its tick is evaluated against the
// mode and duty registers, and the result is registered at the output, so
// the result word is presented from the result register after the sample
// has left the entry register. The mode and duty registers are updated in
// the same edge that loads the result register, which sets the sustained
// rate at one word per cycle. Input ready drops only while the entry stage
// holds a word and a result waits on a stalled sink. Registers are written
// through cfg_we / cfg_index / cfg_data and should only be changed while no
// sample is in flight. No clearing pass runs after reset.
module cc_cv_charge_controller_core #(
    parameter int DUTY_FULL_SCALE = 1000,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cccv_sample_if.sink                          samples,
    cccv_result_if.source                        results,
    input  logic                                 cfg_we,
    input  logic [cccv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cccv_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import cccv_pkg::*;

    localparam int DW = $clog2(DUTY_FULL_SCALE + 1);

    cfg_t                           cfg_reg;

    logic                           s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_current_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_voltage_reg;
    logic                           s1_fault_reg;
    logic                           s1_reset_req_reg;

    mode_t                          mode_reg;
    logic [DW-1:0]                  duty_reg;
    mode_t                          mode_next;
    logic [DW-1:0]                  duty_next;

    logic                           out_valid_reg;
    logic [DUTY_PORT_W-1:0]         out_duty_reg;
    mode_t                          out_mode_reg;

    logic                           advance;
    logic                           s1_ready;

    // Handshake: entry stage moves when the result register is free or drains
    assign advance       = !out_valid_reg || results.ready;
    assign s1_ready      = !s1_valid_reg || advance;
    assign samples.ready = s1_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cc_target_current <= RST_CC_TARGET_CURRENT;
            cfg_reg.cv_target_voltage <= RST_CV_TARGET_VOLTAGE;
            cfg_reg.cc_to_cv_voltage  <= RST_CC_TO_CV_VOLTAGE;
            cfg_reg.cutoff_current    <= RST_CUTOFF_CURRENT;
            cfg_reg.floor_current     <= RST_FLOOR_CURRENT;
            cfg_reg.initial_duty      <= RST_INITIAL_DUTY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CC_TARGET_CURRENT: cfg_reg.cc_target_current <= cfg_data[LEVEL_W-1:0];
                CFG_CV_TARGET_VOLTAGE: cfg_reg.cv_target_voltage <= cfg_data[LEVEL_W-1:0];
                CFG_CC_TO_CV_VOLTAGE:  cfg_reg.cc_to_cv_voltage  <= cfg_data[LEVEL_W-1:0];
                CFG_CUTOFF_CURRENT:    cfg_reg.cutoff_current    <= cfg_data[LEVEL_W-1:0];
                CFG_FLOOR_CURRENT:     cfg_reg.floor_current     <= cfg_data[LEVEL_W-1:0];
                CFG_INITIAL_DUTY:      cfg_reg.initial_duty      <= cfg_data[INIT_DUTY_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Entry stage: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= samples.valid;
    end

    // Entry stage: payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && samples.valid)
        begin
            s1_current_reg   <= samples.measured_current;
            s1_voltage_reg   <= samples.measured_voltage;
            s1_fault_reg     <= samples.fault;
            s1_reset_req_reg <= samples.reset_request;
        end
    end

    // Control tick
    cccv_step #(
        .DUTY_FULL_SCALE (DUTY_FULL_SCALE),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_cccv_step (
        .mode_cur         (mode_reg),
        .duty_cur         (duty_reg),
        .measured_current (s1_current_reg),
        .measured_voltage (s1_voltage_reg),
        .fault            (s1_fault_reg),
        .reset_request    (s1_reset_req_reg),
        .cfg              (cfg_reg),
        .mode_next        (mode_next),
        .duty_next        (duty_next)
    );

    // Mode and duty state, updated once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CC;
            duty_reg <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            mode_reg <= mode_next;
            duty_reg <= duty_next;
        end
    end

    // Result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            out_duty_reg <= DUTY_PORT_W'(duty_next);
            out_mode_reg <= mode_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.duty  = out_duty_reg;
    assign results.mode  = out_mode_reg;

endmodule

>>> rtl/cccv_step.sv
// One control tick: next charge mode and duty from the current state and a sample.
`timescale 1ns / 1ps

module cccv_step #(
    parameter int DUTY_FULL_SCALE = 1000,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  cccv_pkg::mode_t                               mode_cur,
    input  logic [$clog2(DUTY_FULL_SCALE+1)-1:0]          duty_cur,
    input  logic signed [SAMPLE_WIDTH-1:0]                measured_current,
    input  logic signed [SAMPLE_WIDTH-1:0]                measured_voltage,
    input  logic                                          fault,
    input  logic                                          reset_request,
    input  cccv_pkg::cfg_t                                cfg,
    output cccv_pkg::mode_t                               mode_next,
    output logic [$clog2(DUTY_FULL_SCALE+1)-1:0]          duty_next
);
    import cccv_pkg::*;

    localparam int DW       = $clog2(DUTY_FULL_SCALE + 1);
    localparam int COARSE   = DUTY_FULL_SCALE / 100;
    localparam int FINE_RAW = DUTY_FULL_SCALE / 1000;
    localparam int FINE     = (FINE_RAW > 0) ? FINE_RAW : 1;
    // compare width: widest operand plus room for a factor of up to 107
    localparam int MW       = ((SAMPLE_WIDTH > LEVEL_W + 1) ? SAMPLE_WIDTH : LEVEL_W + 1) + 8;
    localparam int IW       = (DW > INIT_DUTY_W) ? DW : INIT_DUTY_W;

    localparam logic [DW-1:0] FS_D     = DW'(DUTY_FULL_SCALE);
    localparam logic [DW-1:0] COARSE_D = DW'(COARSE);
    localparam logic [DW-1:0] FINE_D   = DW'(FINE);
    localparam logic [IW-1:0] FS_I     = IW'(DUTY_FULL_SCALE);

    logic signed [MW-1:0] cur_x;
    logic signed [MW-1:0] vol_x;
    logic signed [MW-1:0] ti_x;
    logic signed [MW-1:0] tv_x;
    logic signed [MW-1:0] ctv_x;
    logic signed [MW-1:0] cutoff_x;
    logic signed [MW-1:0] floor_x;
    logic                 vol_nonneg;

    logic [DW:0]          sum_c;
    logic [DW:0]          sum_f;
    logic [DW-1:0]        up_c;
    logic [DW-1:0]        dn_c;
    logic [DW-1:0]        up_f;
    logic [DW-1:0]        dn_f;
    logic [IW-1:0]        init_ext;
    logic [DW-1:0]        init_sat;

    // Operand alignment: samples sign-extended, levels zero-extended
    assign cur_x      = MW'(measured_current);
    assign vol_x      = MW'(measured_voltage);
    assign ti_x       = MW'({1'b0, cfg.cc_target_current});
    assign tv_x       = MW'({1'b0, cfg.cv_target_voltage});
    assign ctv_x      = MW'({1'b0, cfg.cc_to_cv_voltage});
    assign cutoff_x   = MW'({1'b0, cfg.cutoff_current});
    assign floor_x    = MW'({1'b0, cfg.floor_current});
    assign vol_nonneg = !measured_voltage[SAMPLE_WIDTH-1];

    // Saturating duty steps
    assign sum_c = {1'b0, duty_cur} + {1'b0, COARSE_D};
    assign sum_f = {1'b0, duty_cur} + {1'b0, FINE_D};
    assign up_c  = (sum_c > {1'b0, FS_D}) ? FS_D : sum_c[DW-1:0];
    assign up_f  = (sum_f > {1'b0, FS_D}) ? FS_D : sum_f[DW-1:0];
    assign dn_c  = (duty_cur > COARSE_D) ? (duty_cur - COARSE_D) : '0;
    assign dn_f  = (duty_cur > FINE_D) ? (duty_cur - FINE_D) : '0;

    // Initial duty clipped to full scale
    assign init_ext = IW'(cfg.initial_duty);
    assign init_sat = (init_ext > FS_I) ? FS_D : init_ext[DW-1:0];

    // Mode transitions and duty update
    always_comb
    begin
        mode_next = mode_cur;
        duty_next = duty_cur;
        if (fault)
        begin
            mode_next = MODE_ERROR;
            duty_next = '0;
        end
        else
        begin
            unique case (mode_cur)
                MODE_CC:
                begin
                    priority if (cur_x < floor_x)
                        duty_next = init_sat;
                    else if (cur_x * MW'(10) <= ti_x * MW'(3))
                        duty_next = up_c;
                    else if (cur_x * MW'(10) >= ti_x * MW'(13))
                        duty_next = dn_c;
                    else if (cur_x * MW'(20) <= ti_x * MW'(17))
                        duty_next = up_f;
                    else if (cur_x * MW'(20) >= ti_x * MW'(23))
                        duty_next = dn_f;
                    else
                        duty_next = duty_cur;
                    if (vol_x >= ctv_x)
                        mode_next = MODE_CV;
                end
                MODE_CV:
                begin
                    // outer +-7% band, then inner +-2% band
                    priority if (vol_x * MW'(100) >= tv_x * MW'(107))
                        duty_next = dn_f;
                    else if (vol_x * MW'(100) <= tv_x * MW'(93) && vol_nonneg)
                        duty_next = up_f;
                    else if (vol_x * MW'(50) >= tv_x * MW'(51))
                        duty_next = dn_f;
                    else if (vol_x * MW'(50) <= tv_x * MW'(49) && vol_nonneg)
                        duty_next = up_f;
                    else
                        duty_next = duty_cur;
                    if (cur_x <= cutoff_x)
                    begin
                        mode_next = MODE_CHARGED;
                        duty_next = '0;
                    end
                end
                MODE_CHARGED, MODE_ERROR:
                begin
                    duty_next = '0;
                    if (reset_request)
                        mode_next = MODE_CC;
                end
                default:
                begin
                    mode_next = mode_cur;
                    duty_next = '0;
                end
            endcase
        end
    end

endmodule

>>> rtl/cccv_checker.sv
// Port-level checks of the charge controller core, bound to the top level.
`timescale 1ns / 1ps
`include "cc_cv_charge_controller_core_defines.svh"

module cccv_core_checks #(
    parameter int DUTY_FULL_SCALE = 1000
) (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [9:0] res_duty,
    input logic [1:0] res_mode
);
    import cccv_pkg::*;

    localparam int DUTY_LIMIT = (DUTY_FULL_SCALE > 1023) ? 1023 : DUTY_FULL_SCALE;

    logic hold_mode;

    assign hold_mode = (res_mode == MODE_ERROR) || (res_mode == MODE_CHARGED);

    // A stalled result word holds
    `CCCV_ASSERT_NEXT(a_result_holds, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_duty) && $stable(res_mode), "result word changed while stalled")

    // Duty never exceeds full scale
    `CCCV_ASSERT_NOW(a_duty_range, clk, rst_n, res_valid, res_duty <= 10'(DUTY_LIMIT), "duty above full scale")

    // Error and charged holds drive the PWM off
    `CCCV_ASSERT_NOW(a_hold_duty_zero, clk, rst_n, res_valid && hold_mode, res_duty == '0, "nonzero duty in error or charged mode")

endmodule

bind cc_cv_charge_controller_core cccv_core_checks #(
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
) u_cccv_core_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_duty  (results.duty),
    .res_mode  (results.mode)
);
